// ===== rtl/tdp_pkg.sv =====
// tdp_pkg: shared widths, verdict codes and divider control types
// for the trial division prime test block; no dependencies
package tdp_pkg;

    localparam int NUMBER_W  = 32;
    localparam int VERDICT_W = 2;

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_PRIME     = 2'd0;
    localparam verdict_t VERDICT_COMPOSITE = 2'd1;
    localparam verdict_t VERDICT_INVALID   = 2'd2;

    localparam int MIN_VALID     = 3;
    localparam int FIRST_DIVISOR = 2;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ===== rtl/tdp_number_if.sv =====
// tdp_number_if: valid/ready channel carrying the number under test
// depends on tdp_pkg
interface tdp_number_if import tdp_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);

endinterface

// ===== rtl/tdp_verdict_if.sv =====
// tdp_verdict_if: valid/ready channel carrying the verdict code
// depends on tdp_pkg
interface tdp_verdict_if import tdp_pkg::*; ();

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);

endinterface

// ===== rtl/tdp_div.sv =====
// tdp_div: restoring divider, one quotient bit per cycle
// depends on tdp_pkg (control and status structs)
module tdp_div
    import tdp_pkg::*;
#(
    parameter int NW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctl_t      ctl,
    input  logic [NW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output div_sts_t      sts,
    output logic [NW-1:0] quotient,
    output logic [NW-1:0] remainder
);

    localparam int CW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [NW:0]   rem_shift;
    logic [NW:0]   diff;
    logic          fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NW-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? diff[NW-1:0] : rem_shift[NW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(0))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/trial_division_prime_test_unit.sv =====
// trial_division_prime_test_unit: top level, divisor sequencer around
// one shared restoring divider; depends on tdp_pkg, tdp_div and both channel interfaces
//
//  channel | dir | payload        | beat
//  --------+-----+----------------+----------------------------------
//  req     | in  | number [31:0]  | one number to test
//  rsp     | out | verdict [1:0]  | 0 prime, 1 composite, 2 invalid
//
// only the low min(WIDTH,32) bits of number are tested (NW below)
// each trial divisor passes through S_START, which pulses the divider's start,
// and S_WAIT, which checks quotient and remainder once the divider is done; a
// number below 3 skips the divider and is marked invalid; a prime n is found once
// the trial divisor d exceeds n / d, and a composite at its least factor
// req.ready is high only while the sequencer is idle; the verdict waits in an
// output register, so a new beat can be taken while rsp is stalled
// rst_n clears sequencer and output valid asynchronously
module trial_division_prime_test_unit
    import tdp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input logic                clk,
    input logic                rst_n,
    tdp_number_if.sink         req,
    tdp_verdict_if.source      rsp
);

    // effective operand width: the port only carries 32 bits
    localparam int NW = (WIDTH < NUMBER_W) ? WIDTH : NUMBER_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] d_reg, d_next;
    verdict_t      result_reg, result_next;
    logic          out_valid_reg, out_valid_next;
    verdict_t      verdict_reg, verdict_next;

    div_ctl_t      div_ctl;
    div_sts_t      div_sts;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_rem;
    logic          in_beat;
    logic          out_free;

    // shared divider: one remainder and quotient per trial divisor
    tdp_div #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign in_beat       = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign div_ctl.start = (state_reg == S_START);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;

        // output register drains independently of the sequencer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    n_next = req.number[NW-1:0];
                    d_next = NW'(FIRST_DIVISOR);
                    if (req.number[NW-1:0] < NW'(MIN_VALID))
                    begin
                        result_next = VERDICT_INVALID;
                        state_next  = S_HOLD;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_sts.done)
                begin
                    // loop ends once d > n / d, i.e. d*d > n
                    if (d_reg > div_quo)
                    begin
                        result_next = VERDICT_PRIME;
                        state_next  = S_HOLD;
                    end
                    else if (div_rem == '0)
                    begin
                        result_next = VERDICT_COMPOSITE;
                        state_next  = S_HOLD;
                    end
                    else
                    begin
                        d_next     = d_reg + NW'(1);
                        state_next = S_START;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        result_reg  <= result_next;
        verdict_reg <= verdict_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.verdict = verdict_reg;

endmodule
